// ===== design/gedt_pkg.sv =====
// Shared types and codes of the grid Euclidean distance transform.
`default_nettype none
package gedt_pkg;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_COMPUTE = 2'd1;
	localparam logic [1:0] KIND_QUERY   = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_DONE  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [1:0] REG_COL_COUNT = 2'd1;
	localparam logic [1:0] REG_CELL_SIZE = 2'd2;

	// Scratch memories hold one line of at most 256 cells.
	localparam int LINE_DEPTH = 256;

	// One envelope vertex: its position, its value and value plus position squared.
	typedef struct packed {
		logic [7:0]  v;
		logic [17:0] f;
		logic [17:0] g;
	} vtx_t;

	// One envelope bound: intersection as numerator over positive denominator.
	typedef struct packed {
		logic signed [18:0] num;
		logic [9:0]         den;
	} bnd_t;

	// Sequencer states, one-hot.
	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_CLEAR  = 12'b0000_0000_0010,
		S_F_RD   = 12'b0000_0000_0100,
		S_F_CAP  = 12'b0000_0000_1000,
		S_L_RD   = 12'b0000_0001_0000,
		S_L_CMP  = 12'b0000_0010_0000,
		S_B_RD   = 12'b0000_0100_0000,
		S_B_CMP  = 12'b0000_1000_0000,
		S_Q_CAP  = 12'b0001_0000_0000,
		S_Q_SQRT = 12'b0010_0000_0000,
		S_Q_MUL  = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

endpackage
`default_nettype wire

// ===== design/grid_euclidean_distance_transform.sv =====
// Top level: occupancy grid store and exact squared Euclidean distance transform.
`default_nettype none
// A load beat writes one occupancy cell if row and col lie below MAX_SIDE. A query
// beat inside the active grid reads the stored squared distance (one memory read),
// takes its square root one result bit per cycle (17 steps) and scales it by the
// cell size in one multiply; one outside it returns a range status. A compute beat
// runs one lower envelope per column and then per row, with compare logic shared
// by both passes: forward, each cell is read, captured and tested against the top
// vertex by two small cross products, again per discarded parabola; backward, each
// cell is read and tested for an advance by one product, again per skipped vertex.
// After reset a clearing pass walks both cell stores once, one cell a cycle (65536
// cells at the default size), before the first item is taken.
// Configuration beats are taken at any time but must only be sent while idle.
module grid_euclidean_distance_transform #(
	parameter int MAX_SIDE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  row,
	input  wire logic [7:0]  col,
	input  wire logic        occupied,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [17:0]      squared_cells,
	output logic [32:0]      distance_m,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int SIDE_CAP = (MAX_SIDE < 256) ? MAX_SIDE : 256;
	localparam int RW       = (SIDE_CAP > 1) ? $clog2(SIDE_CAP) : 1;
	localparam int AW       = 2 * RW;
	localparam int DEPTH    = 1 << AW;

	// Configuration registers.
	logic [8:0]  row_count_q, col_count_q;
	logic [23:0] cell_size_q;

	// Sequencer and loop registers.
	gedt_pkg::state_t state_q;
	logic [AW-1:0] clr_q;
	logic       pass_q;
	logic [7:0] i_q, q_q, k_q, top_q;
	logic [17:0] seed_q, fq_q, gq_q;
	logic [33:0] x_q, res_q, bit_q;
	logic [1:0]  r_status_q;
	logic [17:0] r_sq_q;
	logic [32:0] r_dist_q;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [17:0] squared_q;
	logic [32:0] distance_q;

	// Memories and their registered read data.
	logic              occ_mem [DEPTH];
	logic [17:0]       sq_mem  [DEPTH];
	gedt_pkg::vtx_t    vtx_mem [gedt_pkg::LINE_DEPTH];
	gedt_pkg::bnd_t    bnd_mem [gedt_pkg::LINE_DEPTH];
	logic              occ_rd_q;
	logic [17:0]       sq_rd_q;
	gedt_pkg::vtx_t    vtx_rd_q;
	gedt_pkg::bnd_t    bnd_rd_q;

	// Combinational helpers.
	logic [8:0]  rows_act, cols_act, len_last9, lines_last9;
	logic [7:0]  len_last, lines_last;
	logic        in_fire, in_store, q_out_range;
	logic [AW-1:0] in_addr, line_addr, rd_addr;
	logic        occ_we, occ_wd, sq_we;
	logic [AW-1:0] occ_wa, sq_wa;
	logic [17:0] sq_wd;
	logic        vtx_we, bnd_we;
	logic [7:0]  vtx_wa, bnd_ra;
	gedt_pkg::vtx_t vtx_wd;
	gedt_pkg::bnd_t new_bnd;
	logic [17:0] f_cur, g_cur;
	logic signed [18:0] num_cur;
	logic [9:0]  den_cur;
	logic signed [29:0] lhs_prod, rhs_prod;
	logic        pop;
	logic signed [19:0] qb_prod;
	logic        adv;
	logic signed [8:0] dq;
	logic [7:0]  dq_abs;
	logic [18:0] out_sum;
	logic [33:0] sqrt_t;
	logic [41:0] dist_prod;
	logic [18:0] seed_sum;

	// Active grid size, with zero acting as one and large values saturating.
	always_comb begin
		if (row_count_q == 9'd0) begin
			rows_act = 9'd1;
		end else if (row_count_q > 9'(SIDE_CAP)) begin
			rows_act = 9'(SIDE_CAP);
		end else begin
			rows_act = row_count_q;
		end
		if (col_count_q == 9'd0) begin
			cols_act = 9'd1;
		end else if (col_count_q > 9'(SIDE_CAP)) begin
			cols_act = 9'(SIDE_CAP);
		end else begin
			cols_act = col_count_q;
		end
	end

	// Line length and line count of the current pass.
	assign len_last9   = (pass_q ? cols_act : rows_act) - 9'd1;
	assign lines_last9 = (pass_q ? rows_act : cols_act) - 9'd1;
	assign len_last    = len_last9[7:0];
	assign lines_last  = lines_last9[7:0];

	// Input handshake and address decode.
	assign in_ready    = (state_q == gedt_pkg::S_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign in_store    = (int'(row) < MAX_SIDE) && (int'(col) < MAX_SIDE);
	assign q_out_range = ({1'b0, row} >= rows_act) || ({1'b0, col} >= cols_act);
	assign in_addr     = {row[RW-1:0], col[RW-1:0]};
	assign line_addr   = pass_q ? {i_q[RW-1:0], q_q[RW-1:0]} : {q_q[RW-1:0], i_q[RW-1:0]};
	assign rd_addr     = (state_q == gedt_pkg::S_F_RD) ? line_addr : in_addr;
	assign seed_sum    = 19'(rows_act * rows_act) + 19'(cols_act * cols_act) + 19'd1;

	// Value of the cell just read: seeded in the column pass, stored in the row pass.
	assign f_cur = pass_q ? sq_rd_q : (occ_rd_q ? 18'd0 : seed_q);
	assign g_cur = f_cur + 18'(q_q * q_q);

	// Forward step: intersection with the top vertex and the pop test.
	assign num_cur  = $signed({1'b0, gq_q}) - $signed({1'b0, vtx_rd_q.g});
	assign den_cur  = {1'b0, q_q - vtx_rd_q.v, 1'b0};
	assign lhs_prod = num_cur * $signed({1'b0, bnd_rd_q.den});
	assign rhs_prod = bnd_rd_q.num * $signed({1'b0, den_cur});
	assign pop      = (k_q != 8'd0) && (lhs_prod <= rhs_prod);
	assign new_bnd  = '{num: num_cur, den: den_cur};

	// Backward step: advance test and the distance of cell q.
	assign qb_prod = $signed({1'b0, q_q}) * $signed({1'b0, bnd_rd_q.den});
	assign adv     = (k_q < top_q) && (bnd_rd_q.num < qb_prod);
	assign dq      = $signed({1'b0, q_q}) - $signed({1'b0, vtx_rd_q.v});
	assign dq_abs  = dq[8] ? 8'(-dq) : dq[7:0];
	assign out_sum = 19'(dq_abs * dq_abs) + {1'b0, vtx_rd_q.f};

	// Square root step and final scaling.
	assign sqrt_t    = res_q + bit_q;
	assign dist_prod = 42'(res_q[17:0]) * 42'(cell_size_q);

	// Memory write ports.
	always_comb begin
		occ_we = (state_q == gedt_pkg::S_CLEAR) ||
			(in_fire && (kind == gedt_pkg::KIND_LOAD) && in_store);
		occ_wa = (state_q == gedt_pkg::S_CLEAR) ? clr_q : in_addr;
		occ_wd = (state_q == gedt_pkg::S_CLEAR) ? 1'b0 : occupied;
		sq_we  = (state_q == gedt_pkg::S_CLEAR) || ((state_q == gedt_pkg::S_B_CMP) && !adv);
		sq_wa  = (state_q == gedt_pkg::S_CLEAR) ? clr_q : line_addr;
		sq_wd  = (state_q == gedt_pkg::S_CLEAR) ? 18'd0 : out_sum[17:0];
		vtx_we = ((state_q == gedt_pkg::S_F_CAP) && (q_q == 8'd0)) ||
			((state_q == gedt_pkg::S_L_CMP) && !pop);
		bnd_we = (state_q == gedt_pkg::S_L_CMP) && !pop;
		if (state_q == gedt_pkg::S_F_CAP) begin
			vtx_wa = 8'd0;
			vtx_wd = '{v: q_q, f: f_cur, g: g_cur};
		end else begin
			vtx_wa = k_q + 8'd1;
			vtx_wd = '{v: q_q, f: fq_q, g: gq_q};
		end
		bnd_ra = (state_q == gedt_pkg::S_B_RD) ? (k_q + 8'd1) : k_q;
	end

	// Cell stores.
	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		if (sq_we) begin
			sq_mem[sq_wa] <= sq_wd;
		end
		occ_rd_q <= occ_mem[rd_addr];
		sq_rd_q  <= sq_mem[rd_addr];
	end

	// Envelope scratch memories.
	always_ff @(posedge clk) begin
		if (vtx_we) begin
			vtx_mem[vtx_wa] <= vtx_wd;
		end
		if (bnd_we) begin
			bnd_mem[vtx_wa] <= new_bnd;
		end
		vtx_rd_q <= vtx_mem[k_q];
		bnd_rd_q <= bnd_mem[bnd_ra];
	end

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 9'd256;
			col_count_q <= 9'd256;
			cell_size_q <= 24'd3277;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gedt_pkg::REG_ROW_COUNT: row_count_q <= cfg_data[8:0];
				gedt_pkg::REG_COL_COUNT: col_count_q <= cfg_data[8:0];
				gedt_pkg::REG_CELL_SIZE: cell_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			gedt_pkg::S_IDLE: begin
				seed_q     <= seed_sum[17:0];
				r_status_q <= gedt_pkg::STAT_RANGE;
				r_sq_q     <= 18'd0;
				r_dist_q   <= 33'd0;
			end
			gedt_pkg::S_F_CAP: begin
				fq_q <= f_cur;
				gq_q <= g_cur;
			end
			gedt_pkg::S_B_CMP: begin
				r_status_q <= gedt_pkg::STAT_DONE;
				r_sq_q     <= 18'd0;
				r_dist_q   <= 33'd0;
			end
			gedt_pkg::S_Q_CAP: begin
				x_q    <= {sq_rd_q, 16'd0};
				res_q  <= 34'd0;
				r_sq_q <= sq_rd_q;
			end
			gedt_pkg::S_Q_SQRT: begin
				if (x_q >= sqrt_t) begin
					x_q   <= x_q - sqrt_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			gedt_pkg::S_Q_MUL: begin
				r_status_q <= gedt_pkg::STAT_OK;
				r_dist_q   <= dist_prod[40:8];
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gedt_pkg::S_CLEAR;
			clr_q   <= '0;
			pass_q  <= 1'b0;
			i_q     <= 8'd0;
			q_q     <= 8'd0;
			k_q     <= 8'd0;
			top_q   <= 8'd0;
			bit_q   <= 34'd0;
		end else begin
			case (state_q)
				gedt_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= gedt_pkg::S_IDLE;
					end
				end
				gedt_pkg::S_IDLE: begin
					if (in_fire) begin
						case (kind)
							gedt_pkg::KIND_COMPUTE: begin
								pass_q  <= 1'b0;
								i_q     <= 8'd0;
								q_q     <= 8'd0;
								state_q <= gedt_pkg::S_F_RD;
							end
							gedt_pkg::KIND_QUERY: begin
								state_q <= q_out_range ? gedt_pkg::S_DONE : gedt_pkg::S_Q_CAP;
							end
							default: ;
						endcase
					end
				end
				gedt_pkg::S_F_RD: state_q <= gedt_pkg::S_F_CAP;
				gedt_pkg::S_F_CAP: begin
					if (q_q == 8'd0) begin
						k_q <= 8'd0;
						if (len_last == 8'd0) begin
							top_q   <= 8'd0;
							state_q <= gedt_pkg::S_B_RD;
						end else begin
							q_q     <= 8'd1;
							state_q <= gedt_pkg::S_F_RD;
						end
					end else begin
						state_q <= gedt_pkg::S_L_RD;
					end
				end
				gedt_pkg::S_L_RD: state_q <= gedt_pkg::S_L_CMP;
				gedt_pkg::S_L_CMP: begin
					if (pop) begin
						k_q     <= k_q - 8'd1;
						state_q <= gedt_pkg::S_L_RD;
					end else if (q_q == len_last) begin
						top_q   <= k_q + 8'd1;
						k_q     <= 8'd0;
						q_q     <= 8'd0;
						state_q <= gedt_pkg::S_B_RD;
					end else begin
						k_q     <= k_q + 8'd1;
						q_q     <= q_q + 8'd1;
						state_q <= gedt_pkg::S_F_RD;
					end
				end
				gedt_pkg::S_B_RD: state_q <= gedt_pkg::S_B_CMP;
				gedt_pkg::S_B_CMP: begin
					if (adv) begin
						k_q     <= k_q + 8'd1;
						state_q <= gedt_pkg::S_B_RD;
					end else if (q_q != len_last) begin
						q_q     <= q_q + 8'd1;
						state_q <= gedt_pkg::S_B_RD;
					end else begin
						// End of a line: next line, next pass or done.
						q_q <= 8'd0;
						if (i_q != lines_last) begin
							i_q     <= i_q + 8'd1;
							state_q <= gedt_pkg::S_F_RD;
						end else if (!pass_q) begin
							pass_q  <= 1'b1;
							i_q     <= 8'd0;
							state_q <= gedt_pkg::S_F_RD;
						end else begin
							state_q <= gedt_pkg::S_DONE;
						end
					end
				end
				gedt_pkg::S_Q_CAP: begin
					bit_q   <= 34'd1 << 32;
					state_q <= gedt_pkg::S_Q_SQRT;
				end
				gedt_pkg::S_Q_SQRT: begin
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= gedt_pkg::S_Q_MUL;
					end
				end
				gedt_pkg::S_Q_MUL: state_q <= gedt_pkg::S_DONE;
				gedt_pkg::S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= gedt_pkg::S_IDLE;
					end
				end
				default: state_q <= gedt_pkg::S_IDLE;
			endcase
		end
	end

	// Output register: a finished result waits here until its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == gedt_pkg::S_DONE) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == gedt_pkg::S_DONE) && (!out_valid_q || out_ready)) begin
			status_q   <= r_status_q;
			squared_q  <= r_sq_q;
			distance_q <= r_dist_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign squared_cells = squared_q;
	assign distance_m    = distance_q;

	// The backward walk never moves past the last envelope vertex.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gedt_pkg::S_B_CMP) |-> (k_q <= top_q))
		else $error("envelope index beyond top vertex");

	// Every vertex on the stack lies strictly before the parabola being added.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gedt_pkg::S_L_CMP) |-> (vtx_rd_q.v < q_q))
		else $error("envelope vertex not before current cell");

	// The square root walks a single bit down through even positions.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gedt_pkg::S_Q_SQRT) |-> $onehot(bit_q))
		else $error("square root bit lost");

	// A compute result carries zero values.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == gedt_pkg::STAT_DONE)) |->
			((squared_cells == 18'd0) && (distance_m == 33'd0)))
		else $error("compute result with nonzero values");

	// No item is taken while a compute is still in its backward walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gedt_pkg::S_B_CMP) |=> !in_ready)
		else $error("input taken during compute");

endmodule
`default_nettype wire
